>>> hdl/fdg_pkg.sv
// Shared types and constants for the face-down gesture detector.
// No dependencies; fdg_in_if, fdg_ctrl, fdg_dp and the top level import this package.
package fdg_pkg;

  localparam int TIME_W  = 64;
  localparam int ACCEL_W = 16;
  localparam int WIN_W   = 32;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam int UP_FIFO_DEPTH_DEF = 64;

  localparam logic signed [ACCEL_W-1:0] DOWN_THRESHOLD_RST = -16'sd9215;
  localparam logic signed [ACCEL_W-1:0] UP_THRESHOLD_RST   = 16'sd9215;
  localparam logic [WIN_W-1:0]          WINDOW_LENGTH_RST  = 32'd200000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOWN_THRESHOLD = 2'd0,
    REG_UP_THRESHOLD   = 2'd1,
    REG_WINDOW_LENGTH  = 2'd2
  } fdg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted request
    logic pop;     // drop the head entry of the up-time queue
    logic push;    // apply the down/up updates of the current sample
    logic finish;  // evaluate the gesture and load the result register
  } fdg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;    // the up-time queue holds no entry
    logic expired;  // the head entry just read is older than the window
  } fdg_sts_t;

endpackage

>>> hdl/fdg_in_if.sv
// Sample channel: valid/ready handshake carrying one timestamped Z sample.
// Depends on fdg_pkg for the field widths.
interface fdg_in_if
  import fdg_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [TIME_W-1:0]         sample_time;
  logic signed [ACCEL_W-1:0] accel_z;

  modport source (output valid, output sample_time, output accel_z, input ready);
  modport sink   (input valid, input sample_time, input accel_z, output ready);
endinterface

>>> hdl/fdg_out_if.sv
// Result channel: valid/ready handshake carrying one detector result.
// No dependencies.
interface fdg_out_if;
  logic valid;
  logic ready;
  logic face_down;
  logic up_overflow;

  modport source (output valid, output face_down, output up_overflow, input ready);
  modport sink   (input valid, input face_down, input up_overflow, output ready);
endinterface

>>> hdl/fdg_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fdg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/fdg_ctrl.sv
// Sequencing state machine of the face-down gesture detector.
// Depends on fdg_pkg for the command and status structs.
module fdg_ctrl
  import fdg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  fdg_sts_t sts,
  output fdg_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EVAL,
    S_PUSH,
    S_READ,
    S_FINAL
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = sts.empty ? S_PUSH : S_EVAL;
      end
      S_EVAL: begin
        if (sts.expired) begin
          cmd.pop    = 1'b1;
          state_next = S_CHECK;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        state_next = S_FINAL;
      end
      S_FINAL: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CHECK))
    else $error("accepted request did not start the queue check");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !sts.empty)
    else $error("pop issued on an empty up-time queue");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (out_valid && state == S_IDLE))
    else $error("finished result not presented");

endmodule

>>> hdl/fdg_dp.sv
// Datapath of the face-down gesture detector: config registers, sample capture,
// up-time queue pointers and RAM, time comparisons and result register.
// Depends on fdg_pkg and fdg_ram.
module fdg_dp
  import fdg_pkg::*;
#(
  parameter int UP_FIFO_DEPTH = UP_FIFO_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic [TIME_W-1:0]         sample_time,
  input  logic signed [ACCEL_W-1:0] accel_z,
  input  fdg_cmd_t                  cmd,
  output fdg_sts_t                  sts,
  output logic                      face_down,
  output logic                      up_overflow
);

  localparam int AW = (UP_FIFO_DEPTH > 1) ? $clog2(UP_FIFO_DEPTH) : 1;
  localparam int CW = $clog2(UP_FIFO_DEPTH + 1);
  localparam logic [CW-1:0]   FULL_COUNT = CW'(UP_FIFO_DEPTH);
  localparam logic [AW-1:0]   LAST_ADDR  = AW'(UP_FIFO_DEPTH - 1);
  localparam logic [CW:0]     DEPTH_WIDE = (CW+1)'(UP_FIFO_DEPTH);

  logic signed [ACCEL_W-1:0] down_th;
  logic signed [ACCEL_W-1:0] up_th;
  logic [WIN_W-1:0]          window;

  logic [TIME_W-1:0]         now;
  logic signed [ACCEL_W-1:0] z;
  logic [AW-1:0]             head;
  logic [CW-1:0]             count;
  logic [TIME_W-1:0]         latest_down;
  logic [TIME_W-1:0]         last_report;
  logic                      ovf;

  logic [TIME_W-1:0] head_time;
  logic [TIME_W-1:0] win_wide;
  logic [TIME_W-1:0] head_age;
  logic [TIME_W-1:0] down_age;
  logic [TIME_W-1:0] report_age;
  logic [AW-1:0]     head_inc;
  logic [CW:0]       tail_sum;
  logic [AW-1:0]     tail_addr;
  logic              is_up;
  logic              is_down;
  logic              full;
  logic              report;

  assign win_wide   = {{(TIME_W-WIN_W){1'b0}}, window};
  assign head_age   = now - head_time;
  assign down_age   = now - latest_down;
  assign report_age = now - last_report;
  assign head_inc   = (head == LAST_ADDR) ? '0 : head + 1'b1;
  assign is_up      = (z > up_th);
  assign is_down    = (z < down_th);
  assign full       = (count == FULL_COUNT);

  // Tail slot: head plus count, wrapped once. A full queue wraps onto the head.
  assign tail_sum  = {{(CW+1-AW){1'b0}}, head} + {1'b0, count};
  assign tail_addr = (tail_sum >= DEPTH_WIDE) ? AW'(tail_sum - DEPTH_WIDE) : AW'(tail_sum);

  assign sts.empty   = (count == '0);
  assign sts.expired = (head_age > win_wide);

  assign report = (count != '0) && (down_age < win_wide) && (latest_down >= head_time) &&
                  (report_age >= win_wide);

  fdg_ram #(
    .WIDTH (TIME_W),
    .DEPTH (UP_FIFO_DEPTH)
  ) u_up_ram (
    .clk   (clk),
    .we    (cmd.push && is_up),
    .waddr (tail_addr),
    .wdata (now),
    .raddr (head),
    .rdata (head_time)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      down_th     <= DOWN_THRESHOLD_RST;
      up_th       <= UP_THRESHOLD_RST;
      window      <= WINDOW_LENGTH_RST;
      head        <= '0;
      count       <= '0;
      latest_down <= '0;
      last_report <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DOWN_THRESHOLD: down_th <= signed'(cfg_data[ACCEL_W-1:0]);
          REG_UP_THRESHOLD:   up_th   <= signed'(cfg_data[ACCEL_W-1:0]);
          REG_WINDOW_LENGTH:  window  <= cfg_data[WIN_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.pop) begin
        head  <= head_inc;
        count <= count - 1'b1;
      end
      if (cmd.push) begin
        if (is_down) begin
          latest_down <= now;
        end
        if (is_up) begin
          if (full) begin
            head <= head_inc;
          end else begin
            count <= count + 1'b1;
          end
        end
      end
      if (cmd.finish && report) begin
        last_report <= now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now <= sample_time;
      z   <= accel_z;
    end
    if (cmd.push) begin
      ovf <= is_up && full;
    end
    if (cmd.finish) begin
      face_down   <= report;
      up_overflow <= ovf;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("up-time queue count beyond depth");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> (count == $past(count) - 1'b1))
    else $error("pop did not reduce the queue count by one");

endmodule

>>> hdl/face_down_gesture_detector.sv
// Top level of the face-down gesture detector: channel interfaces, config port,
// controller and datapath. Depends on fdg_pkg, fdg_in_if, fdg_out_if, fdg_ctrl, fdg_dp.

// Each request on the samples channel is one timestamped Z acceleration
// sample, and each produces exactly one result on the results channel.
// Samples above up_threshold enter a queue of face-up times held in a RAM of
// UP_FIFO_DEPTH entries; before that, head entries older than window_length
// are dropped one at a time. A sample below down_threshold becomes the latest
// face-down time, and the gesture is reported when that time is inside the
// window, not earlier than the oldest kept face-up time, the queue is not
// empty and the previous report is at least one window old. The block works
// on one sample at a time. For each request the controller checks whether
// the queue is empty; if not, it compares the head entry, read from the RAM,
// with the window and pops it if it has expired, then checks again. When the
// queue is empty or its head is kept, the sample is pushed, the new head is
// read, and the result is loaded once the output register is free. A finished
// result sits in an output register, so a new sample is accepted while the
// previous result waits to be taken. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while the block is idle,
// since the block itself does not enforce this. Writes to index 3 are ignored.
// The queue RAM needs no clearing after reset, since only entries inside the valid count are ever read.
module face_down_gesture_detector
  import fdg_pkg::*;
#(
  parameter int UP_FIFO_DEPTH = UP_FIFO_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  fdg_in_if.sink               samples,
  fdg_out_if.source            results
);

  // Command and status between the sequencer and the datapath.
  fdg_cmd_t cmd;
  fdg_sts_t sts;

  // The controller owns both handshakes; the datapath owns all payload.
  fdg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fdg_dp #(
    .UP_FIFO_DEPTH (UP_FIFO_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_time (samples.sample_time),
    .accel_z     (samples.accel_z),
    .cmd         (cmd),
    .sts         (sts),
    .face_down   (results.face_down),
    .up_overflow (results.up_overflow)
  );

endmodule
